### hw/rtl/crsh_pkg.sv
// ----------------------------------------------------------------------------
// crsh_pkg
// Shared types and constants for the closest ray / segment hit block.
// ----------------------------------------------------------------------------
package crsh_pkg;

   localparam int MAX_SEGMENTS_DEF = 16;

   localparam int COORD_W = 12;
   localparam int DIR_W   = 16;
   localparam int CNT_W   = 5;
   localparam int SLOT_W  = 4;
   localparam int POINT_W = 16;
   localparam int DIST_W  = 17;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_CAST = 1'b1;

   localparam logic [POINT_W-1:0] POINT_MAX = '1;
   localparam logic [DIST_W-1:0]  DIST_MAX  = '1;

   // divider and square root widths
   localparam int DIVN_W = 56;
   localparam int DIVD_W = 40;
   localparam int SQ_W   = 56;
   localparam int ROOT_W = 28;

   typedef struct packed {
      logic [COORD_W-1:0] sx;
      logic [COORD_W-1:0] sy;
      logic [COORD_W-1:0] ex;
      logic [COORD_W-1:0] ey;
   } seg_entry_type;

endpackage

### hw/rtl/crsh_seg_mem.sv
// ----------------------------------------------------------------------------
// crsh_seg_mem
// Segment table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module crsh_seg_mem #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [AW-1:0]           wr_addr,
   input  crsh_pkg::seg_entry_type wr_data,
   input  logic [AW-1:0]           rd_addr,
   output crsh_pkg::seg_entry_type rd_data_ff
);
   import crsh_pkg::*;

   seg_entry_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

endmodule

### hw/rtl/crsh_mul.sv
// ----------------------------------------------------------------------------
// crsh_mul
// Shared signed 32x32 multiplier with registered product.
// ----------------------------------------------------------------------------
module crsh_mul (
   input  logic               clock,
   input  logic signed [31:0] mul_a,
   input  logic signed [31:0] mul_b,
   output logic signed [63:0] prod_ff
);
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

endmodule

### hw/rtl/crsh_div.sv
// ----------------------------------------------------------------------------
// crsh_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module crsh_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [crsh_pkg::DIVN_W-1:0]   dividend,
   input  logic [crsh_pkg::DIVD_W-1:0]   divisor,
   output logic                          done_ff,
   output logic [crsh_pkg::DIVN_W-1:0]   quo_ff
);
   import crsh_pkg::*;

   localparam int CW = $clog2(DIVN_W);
   localparam logic [CW-1:0] LAST = CW'(DIVN_W - 1);

   logic [DIVD_W-1:0] rem_ff, rem_in;
   logic [DIVD_W-1:0] dsr_ff;
   logic [DIVN_W-1:0] quo_in;
   logic [CW-1:0]     cnt_ff;
   logic              busy_ff;
   logic [DIVD_W:0]   trial;
   logic [DIVD_W:0]   diff;
   logic              ge;

   always_comb begin
      trial  = {rem_ff, quo_ff[DIVN_W-1]};
      diff   = trial - {1'b0, dsr_ff};
      ge     = (trial >= {1'b0, dsr_ff});
      rem_in = ge ? diff[DIVD_W-1:0] : trial[DIVD_W-1:0];
      quo_in = {quo_ff[DIVN_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

endmodule

### hw/rtl/crsh_sqrt.sv
// ----------------------------------------------------------------------------
// crsh_sqrt
// Bit-pair integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module crsh_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [crsh_pkg::SQ_W-1:0]     value,
   output logic                          done_ff,
   output logic [crsh_pkg::ROOT_W-1:0]   root
);
   import crsh_pkg::*;

   localparam int CW = $clog2(ROOT_W);
   localparam logic [CW-1:0] LAST = CW'(ROOT_W - 1);
   localparam logic [SQ_W-1:0] BIT_INIT = SQ_W'(1) << (SQ_W - 2);

   logic [SQ_W-1:0] v_ff, res_ff, bit_ff;
   logic [SQ_W-1:0] trial;
   logic [CW-1:0]   cnt_ff;
   logic            busy_ff;

   assign trial = res_ff + bit_ff;
   assign root  = res_ff[ROOT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         v_ff   <= value;
         res_ff <= '0;
         bit_ff <= BIT_INIT;
      end else if (busy_ff) begin
         if (v_ff >= trial) begin
            v_ff   <= v_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

endmodule

### hw/rtl/closest_ray_segment_hit.sv
// ----------------------------------------------------------------------------
// closest_ray_segment_hit
// Nearest wall-segment hit of a ray, computed on one shared multiplier.
//
//   channel  dir  handshake              contents
//   req_     in   req_valid/req_ready    load segment or cast ray
//   rsp_     out  rsp_valid/rsp_ready    hit, slot, point, distance
//   csr_     in   csr_valid/csr_ready    segment_count
//
// A load with an in-range slot writes its table entry when accepted. A cast reads
// and tests each segment in turn, ranks each further hit against the best so far
// on the multiplier, then on a hit runs two point divisions, the square root and
// the distance division, all bit-serial. Reset is synchronous; the table needs no
// clearing pass. req_ready is low while a cast is in work; a finished result
// waits in the output register.
// ----------------------------------------------------------------------------
module closest_ray_segment_hit #(
   parameter int MAX_SEGMENTS = crsh_pkg::MAX_SEGMENTS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_op,
   input  logic [crsh_pkg::SLOT_W-1:0]     req_slot,
   input  logic [crsh_pkg::COORD_W-1:0]    req_seg_start_x,
   input  logic [crsh_pkg::COORD_W-1:0]    req_seg_start_y,
   input  logic [crsh_pkg::COORD_W-1:0]    req_seg_end_x,
   input  logic [crsh_pkg::COORD_W-1:0]    req_seg_end_y,
   input  logic [crsh_pkg::COORD_W-1:0]    req_ray_origin_x,
   input  logic [crsh_pkg::COORD_W-1:0]    req_ray_origin_y,
   input  logic signed [crsh_pkg::DIR_W-1:0] req_ray_dir_x,
   input  logic signed [crsh_pkg::DIR_W-1:0] req_ray_dir_y,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_hit,
   output logic [crsh_pkg::SLOT_W-1:0]     rsp_hit_index,
   output logic [crsh_pkg::POINT_W-1:0]    rsp_hit_x,
   output logic [crsh_pkg::POINT_W-1:0]    rsp_hit_y,
   output logic [crsh_pkg::DIST_W-1:0]     rsp_hit_distance,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [crsh_pkg::CNT_W-1:0]      csr_wdata
);
   import crsh_pkg::*;

   localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

   localparam logic [5:0] S_IDLE = 6'd0,  S_RD   = 6'd1,  S_PREP = 6'd2,
                          S_M0   = 6'd3,  S_M1   = 6'd4,  S_M2   = 6'd5,
                          S_M3   = 6'd6,  S_M4   = 6'd7,  S_M5   = 6'd8,
                          S_M6   = 6'd9,  S_TEST = 6'd10, S_CMP0 = 6'd11,
                          S_CMP1 = 6'd12, S_CMP2 = 6'd13, S_NEXT = 6'd14,
                          S_FIN  = 6'd15, S_PX0  = 6'd16, S_PX1  = 6'd17,
                          S_PX2  = 6'd18, S_PXW  = 6'd19, S_PY0  = 6'd20,
                          S_PY1  = 6'd21, S_PY2  = 6'd22, S_PYW  = 6'd23,
                          S_DM0  = 6'd24, S_DM1  = 6'd25, S_DM2  = 6'd26,
                          S_DSW  = 6'd27, S_DL0  = 6'd28, S_DL1  = 6'd29,
                          S_DDW  = 6'd30, S_OUT  = 6'd31;

   logic [5:0]          state_ff, state_in;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    idx_ff, idx_in, n_ff, n_in, n_eff;
   logic                found_ff, found_in;
   logic [COORD_W-1:0]  ox_ff, ox_in, oy_ff, oy_in;
   logic signed [DIR_W-1:0] rx_ff, rx_in, ry_ff, ry_in;
   logic signed [12:0]  sx_ff, sx_in, sy_ff, sy_in, wx_ff, wx_in, wy_ff, wy_in;
   logic [COORD_W-1:0]  qx_ff, qx_in, qy_ff, qy_in;
   logic signed [63:0]  acc_ff, acc_in;
   logic signed [31:0]  c_ff, c_in, nt_ff, nt_in, nu_ff, nu_in;
   logic signed [31:0]  cc_ff, cc_in, cnt_ff, cnt_in, cnu_ff, cnu_in;
   logic signed [31:0]  bc_ff, bc_in, bnt_ff, bnt_in, bnu_ff, bnu_in;
   logic [SLOT_W-1:0]   bi_ff, bi_in;
   logic signed [12:0]  bsx_ff, bsx_in, bsy_ff, bsy_in;
   logic [COORD_W-1:0]  bqx_ff, bqx_in, bqy_ff, bqy_in;
   logic [ROOT_W-1:0]   len_ff, len_in;
   logic [POINT_W-1:0]  hx_ff, hx_in, hy_ff, hy_in;
   logic [DIST_W-1:0]   dist_ff, dist_in;

   logic                rsp_valid_ff, rsp_valid_in, rsp_hit_ff, rsp_hit_in;
   logic [SLOT_W-1:0]   rsp_idx_ff, rsp_idx_in;
   logic [POINT_W-1:0]  rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [DIST_W-1:0]   rsp_dist_ff, rsp_dist_in;

   logic signed [31:0]  mul_a, mul_b;
   logic signed [63:0]  prod_ff;
   logic                div_start, div_done;
   logic [DIVN_W-1:0]   div_dividend, div_quo;
   logic [DIVD_W-1:0]   div_divisor;
   logic                sqrt_start, sqrt_done;
   logic [SQ_W-1:0]     sqrt_value;
   logic [ROOT_W-1:0]   sqrt_root;

   logic                mem_we;
   seg_entry_type       mem_wdata, mem_rdata;
   logic [AW-1:0]       mem_raddr;

   logic                req_fire, slot_ok;
   logic signed [31:0]  tc, tnt, tnu;
   logic                t_hit;
   logic signed [63:0]  sum;
   logic [63:0]         pnum;

   crsh_seg_mem #(.DEPTH(MAX_SEGMENTS), .AW(AW)) u_mem (
      .clock      (clock),
      .wr_en      (mem_we),
      .wr_addr    (AW'(req_slot)),
      .wr_data    (mem_wdata),
      .rd_addr    (mem_raddr),
      .rd_data_ff (mem_rdata)
   );

   crsh_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod_ff)
   );

   crsh_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done_ff  (div_done),
      .quo_ff   (div_quo)
   );

   crsh_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sqrt_start),
      .value   (sqrt_value),
      .done_ff (sqrt_done),
      .root    (sqrt_root)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign slot_ok   = (9'(req_slot) < 9'(MAX_SEGMENTS));
   assign mem_we    = req_fire && (req_op == OP_LOAD) && slot_ok;
   assign mem_wdata = '{sx: req_seg_start_x, sy: req_seg_start_y,
                        ex: req_seg_end_x, ey: req_seg_end_y};
   assign mem_raddr = AW'(idx_ff);
   assign n_eff     = (9'(count_ff) > 9'(MAX_SEGMENTS)) ? CNT_W'(MAX_SEGMENTS)
                                                        : count_ff;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_hit_index    = rsp_idx_ff;
   assign rsp_hit_x        = rsp_x_ff;
   assign rsp_hit_y        = rsp_y_ff;
   assign rsp_hit_distance = rsp_dist_ff;

   always_comb begin
      tc    = c_ff[31] ? -c_ff : c_ff;
      tnt   = c_ff[31] ? -nt_ff : nt_ff;
      tnu   = c_ff[31] ? -nu_ff : nu_ff;
      t_hit = (c_ff != 0) && !tnt[31] && !tnu[31] && (tnu <= tc);
      sum   = acc_ff + prod_ff;
      pnum  = sum[63] ? 64'd0 : $unsigned(sum);
   end

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;   n_in = n_ff;     found_in = found_ff;
      ox_in = ox_ff;     oy_in = oy_ff;   rx_in = rx_ff;   ry_in = ry_ff;
      sx_in = sx_ff;     sy_in = sy_ff;   wx_in = wx_ff;   wy_in = wy_ff;
      qx_in = qx_ff;     qy_in = qy_ff;   acc_in = acc_ff;
      c_in = c_ff;       nt_in = nt_ff;   nu_in = nu_ff;
      cc_in = cc_ff;     cnt_in = cnt_ff; cnu_in = cnu_ff;
      bc_in = bc_ff;     bnt_in = bnt_ff; bnu_in = bnu_ff; bi_in = bi_ff;
      bsx_in = bsx_ff;   bsy_in = bsy_ff; bqx_in = bqx_ff; bqy_in = bqy_ff;
      len_in = len_ff;   hx_in = hx_ff;   hy_in = hy_ff;   dist_in = dist_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_hit_in = rsp_hit_ff;  rsp_idx_in = rsp_idx_ff;
      rsp_x_in = rsp_x_ff;      rsp_y_in = rsp_y_ff;  rsp_dist_in = rsp_dist_ff;
      mul_a = '0;
      mul_b = '0;
      div_start = 1'b0;
      div_dividend = '0;
      div_divisor = '0;
      sqrt_start = 1'b0;
      sqrt_value = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && (req_op == OP_CAST)) begin
               ox_in = req_ray_origin_x;
               oy_in = req_ray_origin_y;
               rx_in = req_ray_dir_x;
               ry_in = req_ray_dir_y;
               idx_in = '0;
               n_in = n_eff;
               found_in = 1'b0;
               bi_in = '0;
               state_in = (n_eff == '0) ? S_FIN : S_RD;
            end
         end
         S_RD: state_in = S_PREP;
         S_PREP: begin
            sx_in = $signed({1'b0, mem_rdata.ex}) - $signed({1'b0, mem_rdata.sx});
            sy_in = $signed({1'b0, mem_rdata.ey}) - $signed({1'b0, mem_rdata.sy});
            wx_in = $signed({1'b0, mem_rdata.sx}) - $signed({1'b0, ox_ff});
            wy_in = $signed({1'b0, mem_rdata.sy}) - $signed({1'b0, oy_ff});
            qx_in = mem_rdata.sx;
            qy_in = mem_rdata.sy;
            state_in = S_M0;
         end
         S_M0: begin
            mul_a = 32'(rx_ff); mul_b = 32'(sy_ff);
            state_in = S_M1;
         end
         S_M1: begin
            mul_a = 32'(ry_ff); mul_b = 32'(sx_ff);
            acc_in = prod_ff;
            state_in = S_M2;
         end
         S_M2: begin
            mul_a = 32'(wx_ff); mul_b = 32'(sy_ff);
            c_in = 32'(acc_ff - prod_ff);
            state_in = S_M3;
         end
         S_M3: begin
            mul_a = 32'(wy_ff); mul_b = 32'(sx_ff);
            acc_in = prod_ff;
            state_in = S_M4;
         end
         S_M4: begin
            mul_a = 32'(wx_ff); mul_b = 32'(ry_ff);
            nt_in = 32'(acc_ff - prod_ff);
            state_in = S_M5;
         end
         S_M5: begin
            mul_a = 32'(wy_ff); mul_b = 32'(rx_ff);
            acc_in = prod_ff;
            state_in = S_M6;
         end
         S_M6: begin
            nu_in = 32'(acc_ff - prod_ff);
            state_in = S_TEST;
         end
         S_TEST: begin
            cc_in = tc; cnt_in = tnt; cnu_in = tnu;
            if (!t_hit) begin
               state_in = S_NEXT;
            end else if (!found_ff) begin
               found_in = 1'b1;
               bc_in = tc; bnt_in = tnt; bnu_in = tnu;
               bi_in = SLOT_W'(idx_ff);
               bsx_in = sx_ff; bsy_in = sy_ff; bqx_in = qx_ff; bqy_in = qy_ff;
               state_in = S_NEXT;
            end else begin
               state_in = S_CMP0;
            end
         end
         S_CMP0: begin
            mul_a = cnt_ff; mul_b = bc_ff;
            state_in = S_CMP1;
         end
         S_CMP1: begin
            mul_a = bnt_ff; mul_b = cc_ff;
            acc_in = prod_ff;
            state_in = S_CMP2;
         end
         S_CMP2: begin
            if (acc_ff < prod_ff) begin
               bc_in = cc_ff; bnt_in = cnt_ff; bnu_in = cnu_ff;
               bi_in = SLOT_W'(idx_ff);
               bsx_in = sx_ff; bsy_in = sy_ff; bqx_in = qx_ff; bqy_in = qy_ff;
            end
            state_in = S_NEXT;
         end
         S_NEXT: begin
            if ((idx_ff + 1'b1) >= n_ff) begin
               state_in = S_FIN;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = S_RD;
            end
         end
         S_FIN: begin
            if (found_ff) begin
               state_in = S_PX0;
            end else begin
               hx_in = '0; hy_in = '0; dist_in = DIST_MAX; bi_in = '0;
               state_in = S_OUT;
            end
         end
         S_PX0: begin
            mul_a = 32'({1'b0, bqx_ff}); mul_b = bc_ff;
            state_in = S_PX1;
         end
         S_PX1: begin
            mul_a = bnu_ff; mul_b = 32'(bsx_ff);
            acc_in = prod_ff;
            state_in = S_PX2;
         end
         S_PX2: begin
            div_start = 1'b1;
            div_dividend = DIVN_W'({pnum[49:0], 5'b0}) + DIVN_W'($unsigned(bc_ff));
            div_divisor = DIVD_W'({bc_ff, 1'b0});
            state_in = S_PXW;
         end
         S_PXW: begin
            if (div_done) begin
               hx_in = (div_quo > DIVN_W'(POINT_MAX)) ? POINT_MAX : div_quo[POINT_W-1:0];
               state_in = S_PY0;
            end
         end
         S_PY0: begin
            mul_a = 32'({1'b0, bqy_ff}); mul_b = bc_ff;
            state_in = S_PY1;
         end
         S_PY1: begin
            mul_a = bnu_ff; mul_b = 32'(bsy_ff);
            acc_in = prod_ff;
            state_in = S_PY2;
         end
         S_PY2: begin
            div_start = 1'b1;
            div_dividend = DIVN_W'({pnum[49:0], 5'b0}) + DIVN_W'($unsigned(bc_ff));
            div_divisor = DIVD_W'({bc_ff, 1'b0});
            state_in = S_PYW;
         end
         S_PYW: begin
            if (div_done) begin
               hy_in = (div_quo > DIVN_W'(POINT_MAX)) ? POINT_MAX : div_quo[POINT_W-1:0];
               state_in = S_DM0;
            end
         end
         S_DM0: begin
            mul_a = 32'(rx_ff); mul_b = 32'(rx_ff);
            state_in = S_DM1;
         end
         S_DM1: begin
            mul_a = 32'(ry_ff); mul_b = 32'(ry_ff);
            acc_in = prod_ff;
            state_in = S_DM2;
         end
         S_DM2: begin
            sqrt_start = 1'b1;
            sqrt_value = {sum[31:0], 24'b0};
            state_in = S_DSW;
         end
         S_DSW: begin
            if (sqrt_done) begin
               len_in = sqrt_root;
               state_in = S_DL0;
            end
         end
         S_DL0: begin
            mul_a = bnt_ff; mul_b = 32'({1'b0, len_ff});
            state_in = S_DL1;
         end
         S_DL1: begin
            div_start = 1'b1;
            div_dividend = prod_ff[DIVN_W-1:0];
            div_divisor = DIVD_W'({bc_ff, 8'b0});
            state_in = S_DDW;
         end
         S_DDW: begin
            if (div_done) begin
               dist_in = (div_quo > DIVN_W'(DIST_MAX)) ? DIST_MAX : div_quo[DIST_W-1:0];
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in = found_ff;
               rsp_idx_in = bi_ff;
               rsp_x_in = hx_ff;
               rsp_y_in = hy_ff;
               rsp_dist_in = dist_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            count_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;   n_ff <= n_in;
      ox_ff <= ox_in;     oy_ff <= oy_in;   rx_ff <= rx_in;   ry_ff <= ry_in;
      sx_ff <= sx_in;     sy_ff <= sy_in;   wx_ff <= wx_in;   wy_ff <= wy_in;
      qx_ff <= qx_in;     qy_ff <= qy_in;   acc_ff <= acc_in;
      c_ff <= c_in;       nt_ff <= nt_in;   nu_ff <= nu_in;
      cc_ff <= cc_in;     cnt_ff <= cnt_in; cnu_ff <= cnu_in;
      bc_ff <= bc_in;     bnt_ff <= bnt_in; bnu_ff <= bnu_in; bi_ff <= bi_in;
      bsx_ff <= bsx_in;   bsy_ff <= bsy_in; bqx_ff <= bqx_in; bqy_ff <= bqy_in;
      len_ff <= len_in;   hx_ff <= hx_in;   hy_ff <= hy_in;   dist_ff <= dist_in;
      rsp_hit_ff <= rsp_hit_in;  rsp_idx_ff <= rsp_idx_in;
      rsp_x_ff <= rsp_x_in;      rsp_y_ff <= rsp_y_in;  rsp_dist_ff <= rsp_dist_in;
   end

   // a new result only ever comes out of the output state
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && !(rsp_valid_ff && !rsp_ready)) |-> (state_ff == S_OUT))
      else $error("result raised outside output state");

   // a cast transaction blocks the request side on the next cycle
   a_cast_busy: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_op == OP_CAST)) |=> !req_ready)
      else $error("request side ready during cast");

   // a miss reports zero point and saturated distance
   a_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> ((rsp_hit_distance == DIST_MAX) &&
                                   (rsp_hit_x == '0) && (rsp_hit_y == '0) &&
                                   (rsp_hit_index == '0)))
      else $error("miss result carries hit data");

   // the divider and root unit are only started from the sequencer, never both in the same cycle
   a_one_start: assert property (@(posedge clock) disable iff (reset)
      !(div_start && sqrt_start))
      else $error("two units started together");

endmodule
